// File: src/lfu_pkg.sv
// Shared types and constants for the LFU key-value store.
// Used by the top level and the testbench; no dependencies.
`default_nettype none

package lfu_pkg;

  // Default sizing
  localparam int LFU_ENTRIES    = 16;
  localparam int LFU_COUNT_BITS = 16;

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request kind carried in s_axis_tuser
  localparam logic CMD_PUT = 1'b1;

  // Request sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP
  } lfu_state_t;

  // What a write-back sweep does to each entry
  typedef enum logic [1:0] {
    SW_TOUCH,
    SW_DEC,
    SW_INC
  } sweep_mode_t;

endpackage

`default_nettype wire

// File: src/lfu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/lfu_cache_store.sv
// Top level of the LFU key-value store: request sequencer, entry RAM and valid bits.
// Depends on lfu_pkg and lfu_ram.
`default_nettype none

// lfu_cache_store holds up to ENTRIES key/value pairs and evicts by lowest use
// count, taking the least recently used entry among equal counts. A request
// (s_axis_tuser = 0 get, 1 put) is taken only when the block is idle and is
// served by passes over the entry RAM, which has one read and one write port:
// a scan pass reads every entry once to find the key, the eviction candidate
// and the first free slot, then a write-back sweep reads every entry and
// rewrites those whose recency rank, count or contents change. A get miss takes
// a scan pass alone, a get or put hit and an insert add a sweep, and each
// eviction needed before an insert adds another sweep and scan. A get answers
// with one result (m_axis_tuser = found, data zero on a miss); a put answers
// nothing. The result sits in an output register, so the block goes on with its
// sweep and takes the next request while the result waits. The capacity
// register may be written at any time the block is idle; values above ENTRIES
// act as ENTRIES and zero makes every put a no-op.

module lfu_cache_store #(
  parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
  parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
  input  wire logic [0:0]  s_axis_tuser,   // [0] cmd
  // result
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] data
  output logic [0:0]       m_axis_tuser,   // [0] found
  // capacity register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_data
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  typedef struct packed {
    logic [lfu_pkg::KEY_W-1:0]  key;
    logic [lfu_pkg::DATA_W-1:0] data;
    logic [COUNT_BITS-1:0]      count;
    logic [RANK_W-1:0]          rank;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // Sequencer
  lfu_pkg::lfu_state_t  state, state_next;
  lfu_pkg::sweep_mode_t mode, mode_next;

  // Configuration and occupancy
  logic [lfu_pkg::CAP_W-1:0] capacity;
  logic [OCC_W-1:0]          occupancy;
  logic [ENTRIES-1:0]        valid;

  // Request held for the duration of its passes
  logic                       req_put;
  logic [lfu_pkg::KEY_W-1:0]  req_key;
  logic [lfu_pkg::DATA_W-1:0] req_value;

  // Scan results
  logic                       hit;
  logic [IDX_W-1:0]           hit_idx;
  logic [RANK_W-1:0]          hit_rank;
  logic [lfu_pkg::DATA_W-1:0] hit_data;
  logic                       vic_found;
  logic [IDX_W-1:0]           vic_idx;
  logic [COUNT_BITS-1:0]      vic_cnt;
  logic [RANK_W-1:0]          vic_rank;
  logic                       free_found;
  logic [IDX_W-1:0]           free_idx;

  // Pass address generator and read stage
  logic             issuing;
  logic [IDX_W-1:0] issue_idx;
  logic             rd_vld;
  logic             rd_last;
  logic [IDX_W-1:0] rd_idx;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           rd_ent;
  logic             rd_vbit;

  // Write-back
  logic   wr_en;
  entry_t wr_ent;

  // Control strobes
  logic pass_start;
  logic pass_end;
  logic out_load;
  logic evict_go;
  logic insert_done;
  logic out_free;
  logic cap_zero;
  logic must_evict;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == lfu_pkg::ST_IDLE);

  assign rd_ent   = ram_rdata;
  assign rd_vbit  = valid[rd_idx];
  assign pass_end = rd_vld && rd_last;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Capacity above the number of entries acts as a full-size store.
  assign cap_zero   = (capacity == '0);
  assign cap_ext    = CMP_W'(capacity);
  assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign must_evict = (occupancy != '0) && (CMP_W'(occupancy) >= cap_eff);

  lfu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_idx),
    .wdata (wr_ent),
    .raddr (issue_idx),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
      mode  <= lfu_pkg::SW_TOUCH;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  // Next state: scan, decide, then at most one sweep; an eviction sweep loops
  // back to a fresh scan so that the next victim is picked on updated ranks.
  always_comb begin
    state_next  = state;
    mode_next   = mode;
    pass_start  = 1'b0;
    out_load    = 1'b0;
    evict_go    = 1'b0;
    insert_done = 1'b0;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = lfu_pkg::ST_SCAN;
          pass_start = 1'b1;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (pass_end) begin
          state_next = lfu_pkg::ST_DECIDE;
        end
      end
      lfu_pkg::ST_DECIDE: begin
        if (!req_put) begin
          // hold the get until the output register is free
          if (out_free) begin
            out_load = 1'b1;
            if (hit) begin
              state_next = lfu_pkg::ST_SWEEP;
              mode_next  = lfu_pkg::SW_TOUCH;
              pass_start = 1'b1;
            end else begin
              state_next = lfu_pkg::ST_IDLE;
            end
          end
        end else if (cap_zero) begin
          state_next = lfu_pkg::ST_IDLE;
        end else if (hit) begin
          state_next = lfu_pkg::ST_SWEEP;
          mode_next  = lfu_pkg::SW_TOUCH;
          pass_start = 1'b1;
        end else if (must_evict) begin
          evict_go   = 1'b1;
          state_next = lfu_pkg::ST_SWEEP;
          mode_next  = lfu_pkg::SW_DEC;
          pass_start = 1'b1;
        end else if (free_found) begin
          state_next = lfu_pkg::ST_SWEEP;
          mode_next  = lfu_pkg::SW_INC;
          pass_start = 1'b1;
        end else begin
          state_next = lfu_pkg::ST_IDLE;
        end
      end
      lfu_pkg::ST_SWEEP: begin
        if (pass_end) begin
          if (mode == lfu_pkg::SW_DEC) begin
            state_next = lfu_pkg::ST_SCAN;
            pass_start = 1'b1;
          end else begin
            state_next = lfu_pkg::ST_IDLE;
          end
          insert_done = (mode == lfu_pkg::SW_INC);
        end
      end
      default: begin
        state_next = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // Write-back of one entry per cycle during a sweep. The read of entry j+1
  // and the write of entry j share a cycle, so they never hit the same word.
  always_comb begin
    wr_en  = 1'b0;
    wr_ent = rd_ent;
    if (state == lfu_pkg::ST_SWEEP && rd_vld) begin
      case (mode)
        lfu_pkg::SW_TOUCH: begin
          if (rd_idx == hit_idx) begin
            // most recent, count saturates
            wr_en       = 1'b1;
            wr_ent.rank = '0;
            if (rd_ent.count != CNT_MAX) begin
              wr_ent.count = COUNT_BITS'(rd_ent.count + 1'b1);
            end
            if (req_put) begin
              wr_ent.data = req_value;
            end
          end else if (rd_vbit && (rd_ent.rank < hit_rank)) begin
            wr_en       = 1'b1;
            wr_ent.rank = RANK_W'(rd_ent.rank + 1'b1);
          end
        end
        lfu_pkg::SW_DEC: begin
          // close the gap left by the victim
          if (rd_vbit && (rd_ent.rank > vic_rank)) begin
            wr_en       = 1'b1;
            wr_ent.rank = RANK_W'(rd_ent.rank - 1'b1);
          end
        end
        lfu_pkg::SW_INC: begin
          if (rd_idx == free_idx) begin
            wr_en        = 1'b1;
            wr_ent.key   = req_key;
            wr_ent.data  = req_value;
            wr_ent.count = COUNT_BITS'(1);
            wr_ent.rank  = '0;
          end else if (rd_vbit) begin
            wr_en       = 1'b1;
            wr_ent.rank = RANK_W'(rd_ent.rank + 1'b1);
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Address generator: one read per cycle from entry 0 up to the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      if (pass_start) begin
        issuing <= 1'b1;
      end else if (issuing && (issue_idx == LAST_IDX)) begin
        issuing <= 1'b0;
      end
      rd_vld <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    if (pass_start) begin
      issue_idx <= '0;
    end else if (issuing && (issue_idx != LAST_IDX)) begin
      issue_idx <= IDX_W'(issue_idx + 1'b1);
    end
    rd_idx  <= issue_idx;
    rd_last <= (issue_idx == LAST_IDX);
  end

  // Capacity, occupancy and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= lfu_pkg::CAP_RESET;
      occupancy <= '0;
      valid     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (evict_go) begin
        valid[vic_idx] <= 1'b0;
        occupancy      <= OCC_W'(occupancy - 1'b1);
      end else if (insert_done) begin
        valid[free_idx] <= 1'b1;
        occupancy       <= OCC_W'(occupancy + 1'b1);
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_put   <= (s_axis_tuser[0] == lfu_pkg::CMD_PUT);
      req_key   <= s_axis_tdata[31:0];
      req_value <= s_axis_tdata[63:32];
    end
  end

  // Scan: key match, eviction candidate (lowest count, then highest rank),
  // first free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (pass_start && (state_next == lfu_pkg::ST_SCAN)) begin
      hit        <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == lfu_pkg::ST_SCAN && rd_vld) begin
      if (rd_vbit && (rd_ent.key == req_key)) begin
        hit <= 1'b1;
      end
      if (rd_vbit && (!vic_found || (rd_ent.count < vic_cnt) ||
          ((rd_ent.count == vic_cnt) && (rd_ent.rank > vic_rank)))) begin
        vic_found <= 1'b1;
      end
      if (!rd_vbit) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lfu_pkg::ST_SCAN && rd_vld) begin
      if (rd_vbit && (rd_ent.key == req_key)) begin
        hit_idx  <= rd_idx;
        hit_rank <= rd_ent.rank;
        hit_data <= rd_ent.data;
      end
      if (rd_vbit && (!vic_found || (rd_ent.count < vic_cnt) ||
          ((rd_ent.count == vic_cnt) && (rd_ent.rank > vic_rank)))) begin
        vic_idx  <= rd_idx;
        vic_cnt  <= rd_ent.count;
        vic_rank <= rd_ent.rank;
      end
      if (!rd_vbit && !free_found) begin
        free_idx <= rd_idx;
      end
    end
  end

  // Output register: load on a decided get, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser[0] <= hit;
      m_axis_tdata    <= hit ? hit_data : '0;
    end
  end

endmodule

`default_nettype wire

// File: src/lfu_chk.sv
// Port-level checker for lfu_cache_store, bound to the top level.
// No dependencies.
`default_nettype none

module lfu_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // Out of reset: nothing pending, ready for a request.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("block not idle after reset");

  // One request at a time: taking a request closes the input.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // A miss carries zero data.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("miss result with nonzero data");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind lfu_cache_store lfu_chk u_lfu_chk (.*);

`default_nettype wire

// File: tb/sv/lfu_store_checker.sv
`timescale 1ns / 1ps
// Port checker for lfu_cache_store: mirrors the store from the accepted requests
// and capacity writes, and compares each accepted get result. Depends on lfu_pkg.

module lfu_store_checker #(
  parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
  parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]       s_axis_tuser,   // [0] cmd
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [31:0]      m_axis_tdata,   // [31:0] data
  input  logic [0:0]       m_axis_tuser,   // [0] found
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic                       found;
    logic [lfu_pkg::DATA_W-1:0] data;
  } lookup_t;

  // Mirror of the store
  logic                       held     [ENTRIES];
  logic [lfu_pkg::KEY_W-1:0]  held_key [ENTRIES];
  logic [lfu_pkg::DATA_W-1:0] held_data[ENTRIES];
  logic [COUNT_BITS-1:0]      uses     [ENTRIES];
  int unsigned                rank     [ENTRIES];
  int unsigned                fill;
  logic [lfu_pkg::CAP_W-1:0]  capacity;

  lookup_t lookups_due[$];
  int      errors = 0;

  function automatic int find_slot(input logic [lfu_pkg::KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (held[i] && held_key[i] == k) return i;
    end
    return -1;
  endfunction

  // make entry i the most recent and count one more use, saturating
  function automatic void bump_entry(input int i);
    int unsigned r;
    r = rank[i];
    for (int j = 0; j < ENTRIES; j++) begin
      if (held[j] && rank[j] < r) rank[j]++;
    end
    rank[i] = 0;
    if (uses[i] != '1) uses[i]++;
  endfunction

  // drop the entry with the lowest count, the oldest among ties
  function automatic void drop_coldest();
    int          v;
    int unsigned r;
    v = -1;
    for (int j = 0; j < ENTRIES; j++) begin
      if (held[j]) begin
        if (v < 0) v = j;
        else if (uses[j] < uses[v] || (uses[j] == uses[v] && rank[j] > rank[v])) v = j;
      end
    end
    if (v < 0) return;
    r = rank[v];
    held[v] = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (held[j] && rank[j] > r) rank[j]--;
    end
    if (fill > 0) fill--;
  endfunction

  function automatic void admit_key(input logic [lfu_pkg::KEY_W-1:0] k,
                                    input logic [lfu_pkg::DATA_W-1:0] d,
                                    input int unsigned cap);
    int slot;
    slot = -1;
    while (fill >= cap && fill > 0) drop_coldest();
    for (int j = 0; j < ENTRIES; j++) begin
      if (!held[j]) begin
        if (slot < 0) slot = j;
      end else begin
        rank[j]++;
      end
    end
    if (slot < 0) return;
    held[slot]      = 1'b1;
    held_key[slot]  = k;
    held_data[slot] = d;
    uses[slot]      = COUNT_BITS'(1);
    rank[slot]      = 0;
    fill++;
  endfunction

  function automatic void apply_request(input logic cmd,
                                        input logic [lfu_pkg::KEY_W-1:0] k,
                                        input logic [lfu_pkg::DATA_W-1:0] d);
    int unsigned cap;
    int          i;
    lookup_t     res;
    cap = (capacity > ENTRIES) ? ENTRIES : capacity;
    i   = find_slot(k);
    if (cmd != lfu_pkg::CMD_PUT) begin
      res.found = (i >= 0);
      res.data  = (i >= 0) ? held_data[i] : '0;
      lookups_due.push_back(res);
      if (i >= 0) bump_entry(i);
    end else if (cap != 0) begin
      if (i >= 0) begin
        held_data[i] = d;
        bump_entry(i);
      end else begin
        admit_key(k, d, cap);
      end
    end
  endfunction

  function automatic void check_result();
    lookup_t want;
    if (lookups_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] result with no get pending: found %0d data %h",
                 $realtime, m_axis_tuser[0], m_axis_tdata);
      return;
    end
    want = lookups_due.pop_front();
    if (want.found !== m_axis_tuser[0] || want.data !== m_axis_tdata) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] get result: found exp %0d got %0d, data exp %h got %h",
                 $realtime, want.found, m_axis_tuser[0], want.data, m_axis_tdata);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        held[i] = 1'b0;
        uses[i] = '0;
        rank[i] = 0;
      end
      fill     = 0;
      capacity = lfu_pkg::CAP_RESET;
      lookups_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        apply_request(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
    outstanding <= lookups_due.size();
    mismatches  <= errors;
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for lfu_cache_store: drives requests and capacity writes, stalls
// the result side, and gives the verdict. Depends on lfu_pkg and lfu_store_checker.

module tb_top;

  localparam logic CMD_GET = 1'b0;

  // A put into a full store that was just shrunk to capacity one evicts every
  // entry before inserting. Allow twice that worst case before touching the
  // capacity register or ending.
  localparam int QUIET_CYCLES = 2 * (lfu_pkg::LFU_ENTRIES + 1) *
                                (2 * lfu_pkg::LFU_ENTRIES + 4);
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 56;
  localparam int HOT_KEYS     = 24;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata = '0;    // [31:0] key, [63:32] value
  logic [0:0]       s_axis_tuser = '0;    // [0] cmd
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b1;
  logic [31:0]      m_axis_tdata;         // [31:0] data
  logic [0:0]       m_axis_tuser;         // [0] found
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [lfu_pkg::CAP_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;

  // Turns off all idling for the last part of the run.
  logic calm = 1'b0;
  int   rx_hold = 0;
  int   cycles = 0;

  logic [lfu_pkg::KEY_W-1:0] hot_keys[HOT_KEYS];
  logic [lfu_pkg::CAP_W-1:0] phase_caps[PHASES];

  always #5 clk = ~clk;

  lfu_cache_store u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  lfu_store_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Result side: hold tready low in bursts of random length, so the output
  // register fills while the block is still sweeping and a new request may
  // arrive behind a waiting result.
  always @(posedge clk) begin
    if (rst || calm) begin
      rx_hold       <= 0;
      m_axis_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= (rx_hold == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      rx_hold       <= $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it. Now and then idle
  // the request side first, so gaps land on every part of a scan or sweep.
  task automatic send_request(input logic cmd, input logic [lfu_pkg::KEY_W-1:0] k,
                              input logic [lfu_pkg::DATA_W-1:0] v);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {v, k};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic put_pair(input logic [lfu_pkg::KEY_W-1:0] k,
                          input logic [lfu_pkg::DATA_W-1:0] v);
    send_request(lfu_pkg::CMD_PUT, k, v);
  endtask

  // The value field of a get is don't-care; fill it anyway.
  task automatic get_key(input logic [lfu_pkg::KEY_W-1:0] k);
    send_request(CMD_GET, k, $urandom());
  endtask

  // Stop offering requests, let every get answer, then give a trailing put
  // time to finish its evictions and sweep.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small hot set, so hits, updates and evictions are
  // common; the rest are fully random keys that nearly always miss.
  task automatic send_random();
    logic [lfu_pkg::KEY_W-1:0] k;
    if ($urandom_range(0, 9) < 8)
      k = ($urandom_range(0, 1) != 0) ? hot_keys[$urandom_range(0, 5)]
                                      : hot_keys[$urandom_range(0, HOT_KEYS - 1)];
    else
      k = $urandom();
    send_request(($urandom_range(0, 1) != 0) ? lfu_pkg::CMD_PUT : CMD_GET, k, $urandom());
  endtask

  initial begin
    hot_keys[0] = 32'h8000_0000;
    hot_keys[1] = 32'h7fff_ffff;
    hot_keys[2] = 32'h0000_0000;
    hot_keys[3] = 32'hffff_ffff;
    for (int i = 4; i < HOT_KEYS; i++) hot_keys[i] = $urandom();
    phase_caps = '{5'd16, 5'd4, 5'd31, 5'd0, 5'd2, 5'd9, 5'd16, 5'd16};
    phase_caps[6] = lfu_pkg::CAP_W'($urandom_range(0, 31));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: miss on an empty store, extreme keys and values,
    // hits, and an update of a present key.
    get_key(32'h0000_0000);
    put_pair(32'h8000_0000, 32'h7fff_ffff);
    put_pair(32'h7fff_ffff, 32'h8000_0000);
    put_pair(32'h0000_0000, 32'h0000_0000);
    put_pair(32'hffff_ffff, 32'hffff_ffff);
    get_key(32'h8000_0000);
    get_key(32'h7fff_ffff);
    get_key(32'h0000_0000);
    get_key(32'hffff_ffff);
    put_pair(32'hffff_ffff, 32'h5a5a_5a5a);
    get_key(32'hffff_ffff);

    // Capacity zero: drop every put, new key or not; gets still hit.
    settle();
    write_capacity(5'd0);
    put_pair(32'h1111_1111, 32'h0000_0001);
    put_pair(32'h0000_0000, 32'hdead_beef);
    get_key(32'h0000_0000);
    get_key(32'h1111_1111);

    // Capacity one below occupancy four: the next new key evicts all four.
    settle();
    write_capacity(5'd1);
    put_pair(32'h2222_2222, 32'h3333_3333);
    get_key(32'h8000_0000);
    get_key(32'h2222_2222);

    // Capacity three: evict by lowest count, then the oldest among equal counts.
    settle();
    write_capacity(5'd3);
    put_pair(32'h0000_00a0, 32'h0000_0a0a);
    put_pair(32'h0000_00b0, 32'h0000_0b0b);
    get_key(32'h0000_00a0);
    put_pair(32'h0000_00c0, 32'h0000_0c0c);
    get_key(32'h0000_00b0);
    put_pair(32'h0000_00d0, 32'h0000_0d0d);
    get_key(32'h0000_00d0);
    put_pair(32'h0000_00e0, 32'h0000_0e0e);
    get_key(32'h2222_2222);

    // Random phases; capacity 31 acts as the full store, and shrinking from a
    // full store forces chains of evictions. The last phase runs with no idling.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_capacity(phase_caps[p]);
      if (p == PHASES - 1) calm <= 1'b1;
      repeat (PHASE_ITEMS) send_random();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (QUIET_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
